// ===== src/tss_pkg.sv =====
// shared constants and byte classification for the text stream statistics block
`timescale 1ns / 1ps

package tss_pkg;

    localparam int BYTE_WIDTH   = 8;
    localparam int OUT_WIDTH    = 32;
    localparam int HIST_ENTRIES = 256;
    localparam int HIST_AW      = $clog2(HIST_ENTRIES);

    localparam logic [BYTE_WIDTH-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [BYTE_WIDTH-1:0] CHAR_DIGIT_LO  = 8'd48;
    localparam logic [BYTE_WIDTH-1:0] CHAR_DIGIT_HI  = 8'd57;
    localparam logic [BYTE_WIDTH-1:0] SEP_LOW_MAX    = 8'd64;
    localparam logic [BYTE_WIDTH-1:0] SEP_MID_MIN    = 8'd91;
    localparam logic [BYTE_WIDTH-1:0] SEP_MID_MAX    = 8'd96;
    localparam logic [BYTE_WIDTH-1:0] SEP_HIGH_MIN   = 8'd123;
    localparam logic [BYTE_WIDTH-1:0] SEP_HIGH_MAX   = 8'd127;

    typedef logic [BYTE_WIDTH-1:0] byte_t;
    typedef logic [OUT_WIDTH-1:0]  total_t;

    function automatic logic is_word_byte(input byte_t b);
        logic sep;
        sep = (b <= SEP_LOW_MAX)
            || ((b >= SEP_MID_MIN) && (b <= SEP_MID_MAX))
            || ((b >= SEP_HIGH_MIN) && (b <= SEP_HIGH_MAX));
        return !sep;
    endfunction

    function automatic logic is_digit_byte(input byte_t b);
        return (b >= CHAR_DIGIT_LO) && (b <= CHAR_DIGIT_HI);
    endfunction

endpackage

// ===== src/tss_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/text_stream_statistics.sv =====
// top level: running byte, line, digit and word totals plus a byte value histogram
// path: an accepted word is held in stage 1, then registered to the m_ports
// throughput: one word per cycle unless the output stalls; the histogram ram is
//   read at accept and written on advance, last write forwarded to the next read
// reset: synchronous active-low aresetn clears the totals, the in-word flag
//   and the per-entry valid bits, so the histogram reads as zero at once
`timescale 1ns / 1ps

module text_stream_statistics #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tss_pkg::byte_t         s_text_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tss_pkg::total_t        m_byte_total,
    output tss_pkg::total_t        m_line_total,
    output tss_pkg::total_t        m_digit_total,
    output tss_pkg::total_t        m_word_total,
    output tss_pkg::total_t        m_value_total,
    output logic                   m_inside_word
);

    import tss_pkg::*;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    // stage 1 and forwarding state
    logic                 s1_valid_reg;
    byte_t                s1_byte_reg;
    logic                 fwd_valid_reg;
    logic [HIST_AW-1:0]   fwd_addr_reg;
    count_t               fwd_data_reg;
    logic [HIST_ENTRIES-1:0] hist_valid_reg;

    // running totals
    count_t bytes_reg,  bytes_next;
    count_t lines_reg,  lines_next;
    count_t digits_reg, digits_next;
    count_t words_reg,  words_next;
    logic   in_word_reg, in_word_next;

    // output stage
    logic   m_valid_reg;
    total_t m_byte_reg, m_line_reg, m_digit_reg, m_word_reg, m_value_reg;
    logic   m_inside_reg;

    logic   accept;
    logic   advance;
    count_t ram_rdata;
    count_t hist_old;
    count_t hist_new;
    logic   word_byte;
    logic [HIST_AW-1:0] s1_addr;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign s1_addr = s1_byte_reg[HIST_AW-1:0];

    tss_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(HIST_ENTRIES)
    ) u_hist_ram (
        .clk   (aclk),
        .we    (advance),
        .waddr (s1_addr),
        .wdata (hist_new),
        .re    (accept),
        .raddr (s_text_byte[HIST_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr)) begin
            hist_old = fwd_data_reg;
        end else if (hist_valid_reg[s1_addr]) begin
            hist_old = ram_rdata;
        end else begin
            hist_old = '0;
        end
        hist_new = (hist_old == COUNT_MAX) ? hist_old : hist_old + count_t'(1);
    end

    always_comb begin
        word_byte    = is_word_byte(s1_byte_reg);
        bytes_next   = (bytes_reg == COUNT_MAX) ? bytes_reg : bytes_reg + count_t'(1);
        lines_next   = lines_reg;
        digits_next  = digits_reg;
        words_next   = words_reg;
        in_word_next = word_byte;
        if ((s1_byte_reg == CHAR_NEWLINE) && (lines_reg != COUNT_MAX)) begin
            lines_next = lines_reg + count_t'(1);
        end
        if (is_digit_byte(s1_byte_reg) && (digits_reg != COUNT_MAX)) begin
            digits_next = digits_reg + count_t'(1);
        end
        if (word_byte && !in_word_reg && (words_reg != COUNT_MAX)) begin
            words_next = words_reg + count_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            hist_valid_reg <= '0;
            bytes_reg      <= '0;
            lines_reg      <= '0;
            digits_reg     <= '0;
            words_reg      <= '0;
            in_word_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                fwd_valid_reg           <= 1'b1;
                hist_valid_reg[s1_addr] <= 1'b1;
                bytes_reg               <= bytes_next;
                lines_reg               <= lines_next;
                digits_reg              <= digits_next;
                words_reg               <= words_next;
                in_word_reg             <= in_word_next;
                m_valid_reg             <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_byte_reg <= s_text_byte;
        end
        if (advance) begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= hist_new;
            m_byte_reg   <= OUT_WIDTH'(bytes_next);
            m_line_reg   <= OUT_WIDTH'(lines_next);
            m_digit_reg  <= OUT_WIDTH'(digits_next);
            m_word_reg   <= OUT_WIDTH'(words_next);
            m_value_reg  <= OUT_WIDTH'(hist_new);
            m_inside_reg <= in_word_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_byte_total  = m_byte_reg;
    assign m_line_total  = m_line_reg;
    assign m_digit_total = m_digit_reg;
    assign m_word_total  = m_word_reg;
    assign m_value_total = m_value_reg;
    assign m_inside_word = m_inside_reg;

endmodule

// ===== src/tss_checker.sv =====
// port-level checker for the text stream statistics block, bound to the top level
`timescale 1ns / 1ps

module tss_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input tss_pkg::byte_t         s_text_byte,
    input logic                   m_valid,
    input logic                   m_ready,
    input tss_pkg::total_t        m_byte_total,
    input tss_pkg::total_t        m_line_total,
    input tss_pkg::total_t        m_digit_total,
    input tss_pkg::total_t        m_word_total,
    input tss_pkg::total_t        m_value_total,
    input logic                   m_inside_word
);

    import tss_pkg::*;

    // a held result word keeps its byte, value and word totals
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_total)
            && $stable(m_value_total) && $stable(m_word_total))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // partial totals never pass the byte total
    a_total_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_line_total <= m_byte_total) && (m_digit_total <= m_byte_total)
            && (m_word_total <= m_byte_total) && (m_value_total <= m_byte_total))
        else $error("total exceeds byte total");

    a_word_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_inside_word |-> (m_word_total != '0) && (m_value_total != '0))
        else $error("word byte without a counted word");

endmodule

bind text_stream_statistics tss_checker u_tss_checker (.*);
